// File: hdl/grdda_pkg.sv
// ----------------------------------------------------------------------------
// grdda_pkg: shared types and constants for the grid ray traversal block
// Field widths, reciprocal divider sizing, register indexes, opcodes and
// sequencer states.
// ----------------------------------------------------------------------------
package grdda_pkg;

	localparam int SCREEN_COLUMNS = 1024;

	localparam int POS_W      = 22;
	localparam int FRAC_W     = 16;
	localparam int DIR_W      = 16;
	localparam int COL_W      = 10;
	localparam int CELL_W     = 8;
	localparam int DIST_W     = 32;
	localparam int MAG_W      = 16;
	localparam int OFFS_W     = 14;
	localparam int OFFS_MAG_W = 13;
	localparam int SPAN_W     = FRAC_W + 1;
	localparam int MUL_A_W    = DIST_W;
	localparam int PROD_W     = MUL_A_W + SPAN_W;
	localparam int CFG_IDX_W  = 3;

	// reciprocal divider: quotient bits retired per cycle
	localparam int DIV_STEPS = 2;
	localparam int DIV_ITERS = DIST_W / DIV_STEPS;
	localparam int DIV_CNT_W = $clog2(DIV_ITERS);

	localparam logic [DIST_W-1:0] RECIP_NUM = 32'h4000_0000;
	localparam logic [DIST_W-1:0] DIST_MAX  = '1;

	localparam logic signed [CELL_W-1:0] CELL_MIN = -8'sd128;
	localparam logic signed [CELL_W-1:0] CELL_MAX = 8'sd127;
	localparam logic signed [DIR_W-1:0]  RAY_MIN  = -16'sd32768;
	localparam logic signed [DIR_W-1:0]  RAY_MAX  = 16'sd32767;
	localparam logic signed [DIR_W-1:0]  VIEW_DIR_X_RESET = 16'sd16384;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POS_X      = 3'd0,
		REG_POS_Y      = 3'd1,
		REG_VIEW_DIR_X = 3'd2,
		REG_VIEW_DIR_Y = 3'd3,
		REG_PLANE_X    = 3'd4,
		REG_PLANE_Y    = 3'd5
	} cfg_reg_t;

	typedef enum logic {
		OP_START   = 1'b0,
		OP_ADVANCE = 1'b1
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_X,
		ST_MUL_Y,
		ST_RAY_Y,
		ST_DIV_X,
		ST_DIV_Y,
		ST_SIDE_X,
		ST_SIDE_Y,
		ST_SIDE_FIN,
		ST_DONE
	} state_t;

endpackage

// File: hdl/grdda_recip.sv
// ----------------------------------------------------------------------------
// grdda_recip: iterative reciprocal divider
// Computes 2^30 / divisor by restoring division, DIV_STEPS quotient bits per
// cycle. A zero divisor yields all ones.
// ----------------------------------------------------------------------------
module grdda_recip
	import grdda_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [MAG_W-1:0]  divisor,
	output logic              done,
	output logic [DIST_W-1:0] quotient
);

	logic                 busy_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [MAG_W:0]       rem_q;
	logic [DIST_W-1:0]    num_q;
	logic [MAG_W-1:0]     div_q;
	logic [MAG_W:0]       rem_d;
	logic [DIST_W-1:0]    num_d;

	// shift numerator bits out the top, quotient bits in at the bottom
	always_comb begin
		rem_d = rem_q;
		num_d = num_q;
		for (int i = 0; i < DIV_STEPS; i++) begin
			rem_d = {rem_d[MAG_W-1:0], num_d[DIST_W-1]};
			num_d = {num_d[DIST_W-2:0], 1'b0};
			if (rem_d >= {1'b0, div_q}) begin
				rem_d    = rem_d - {1'b0, div_q};
				num_d[0] = 1'b1;
			end
		end
	end

	assign done     = busy_q && (cnt_q == DIV_CNT_W'(DIV_ITERS - 1));
	assign quotient = num_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (done) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			num_q <= RECIP_NUM;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_d;
			num_q <= num_d;
		end
	end

endmodule

// File: hdl/grid_ray_dda_traversal.sv
// ----------------------------------------------------------------------------
// grid_ray_dda_traversal: DDA grid ray traversal for a column renderer
// Start sets up a ray from a screen column; advance steps to the next cell.
// ----------------------------------------------------------------------------
// Start item: ray setup (MUL_X, MUL_Y, RAY_Y) on the shared multiplier, two
// reciprocal divisions, side setup (SIDE_X to SIDE_FIN), result load in DONE
// when the output is free; no new item until idle. Advance item: result the
// cycle after the transfer, one item per cycle while out_ready holds. The
// output register lets a new item transfer while the result is taken.
// Reset (arst_n low) clears state and loads register defaults.
// ----------------------------------------------------------------------------
module grid_ray_dda_traversal
	import grdda_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [POS_W-1:0]         cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     op,
	input  logic [COL_W-1:0]         column,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [CELL_W-1:0] cell_x,
	output logic signed [CELL_W-1:0] cell_y,
	output logic                     hit_side,
	output logic [DIST_W-1:0]        dist_x,
	output logic [DIST_W-1:0]        dist_y,
	output logic signed [DIR_W-1:0]  ray_x,
	output logic signed [DIR_W-1:0]  ray_y
);

	function automatic logic signed [CELL_W-1:0] step_cell(
		input logic signed [CELL_W-1:0] c,
		input logic                     neg
	);
		logic signed [CELL_W-1:0] r;
		r = c;
		if (neg) begin
			if (c != CELL_MIN) r = c - 8'sd1;
		end else begin
			if (c != CELL_MAX) r = c + 8'sd1;
		end
		return r;
	endfunction

	function automatic logic [DIST_W-1:0] sat_add(
		input logic [DIST_W-1:0] a,
		input logic [DIST_W-1:0] b
	);
		logic [DIST_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[DIST_W] ? DIST_MAX : s[DIST_W-1:0];
	endfunction

	// configuration
	logic [POS_W-1:0]        pos_x_q, pos_y_q;
	logic signed [DIR_W-1:0] view_dir_x_q, view_dir_y_q, plane_x_q, plane_y_q;

	// traversal state
	state_t                   state_q, state_d;
	logic signed [DIR_W-1:0]  ray_x_q, ray_y_q;
	logic [DIST_W-1:0]        delta_x_q, delta_y_q;
	logic [DIST_W-1:0]        side_x_q, side_y_q;
	logic signed [CELL_W-1:0] cur_cell_x_q, cur_cell_y_q;
	logic                     step_neg_x_q, step_neg_y_q, last_side_q;
	logic                     offs_neg_q;
	logic [OFFS_MAG_W-1:0]    offs_mag_q;
	logic [PROD_W-1:0]        prod_q;

	// output register
	logic                     out_valid_q;
	logic signed [CELL_W-1:0] cell_x_q, cell_y_q;
	logic                     hit_side_q;
	logic [DIST_W-1:0]        dist_x_q, dist_y_q;
	logic signed [DIR_W-1:0]  ray_x_out_q, ray_y_out_q;

	// control and datapath nets
	logic                     in_fire, adv_fire, out_free, fin_load;
	logic                     div_start, div_done;
	logic [MAG_W-1:0]         div_divisor;
	logic [DIST_W-1:0]        div_quot;
	logic [MUL_A_W-1:0]       mul_a;
	logic [SPAN_W-1:0]        mul_b;
	logic [PROD_W-1:0]        mul_p;
	logic signed [DIR_W-1:0]  fin_dir;
	logic                     fin_neg;
	logic [DIST_W-1:0]        q_mag;
	logic signed [DIST_W:0]   q_s, ray_sum;
	logic signed [DIR_W-1:0]  ray_sat;
	logic signed [OFFS_W-1:0] offs_s;
	logic [OFFS_W-1:0]        offs_abs;
	logic [MAG_W-1:0]         plane_x_mag, plane_y_mag, ray_x_mag, ray_y_mag;
	logic [SPAN_W-1:0]        span_x, span_y;
	logic [DIST_W-1:0]        side_sat;
	logic                     adv_x;
	logic [DIST_W-1:0]        nx_side_x, nx_side_y;
	logic signed [CELL_W-1:0] nx_cell_x, nx_cell_y;

	assign out_free = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;
	assign adv_fire = in_fire && (op_t'(op) == OP_ADVANCE);

	assign plane_x_mag = plane_x_q[DIR_W-1] ? MAG_W'(-plane_x_q) : MAG_W'(plane_x_q);
	assign plane_y_mag = plane_y_q[DIR_W-1] ? MAG_W'(-plane_y_q) : MAG_W'(plane_y_q);
	assign ray_x_mag   = ray_x_q[DIR_W-1] ? MAG_W'(-ray_x_q) : MAG_W'(ray_x_q);
	assign ray_y_mag   = ray_y_q[DIR_W-1] ? MAG_W'(-ray_y_q) : MAG_W'(ray_y_q);

	assign offs_s   = OFFS_W'({column, 1'b0}) - OFFS_W'(SCREEN_COLUMNS);
	assign offs_abs = offs_s[OFFS_W-1] ? OFFS_W'(-offs_s) : OFFS_W'(offs_s);

	assign span_x = step_neg_x_q ? SPAN_W'(pos_x_q[FRAC_W-1:0])
		: SPAN_W'(1 << FRAC_W) - SPAN_W'(pos_x_q[FRAC_W-1:0]);
	assign span_y = step_neg_y_q ? SPAN_W'(pos_y_q[FRAC_W-1:0])
		: SPAN_W'(1 << FRAC_W) - SPAN_W'(pos_y_q[FRAC_W-1:0]);

	// shared multiplier
	assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

	// ray component: dir + plane * offset / columns, truncated toward zero
	assign q_mag   = DIST_W'(prod_q / SCREEN_COLUMNS);
	assign q_s     = fin_neg ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
	assign ray_sum = (DIST_W + 1)'(fin_dir) + q_s;
	assign ray_sat = (ray_sum > (DIST_W + 1)'(RAY_MAX)) ? RAY_MAX
		: (ray_sum < (DIST_W + 1)'(RAY_MIN)) ? RAY_MIN : DIR_W'(ray_sum);

	assign side_sat = prod_q[PROD_W-1] ? DIST_MAX : prod_q[PROD_W-2:FRAC_W];

	// advance: cross x only on strictly smaller distance
	assign adv_x     = side_x_q < side_y_q;
	assign nx_side_x = adv_x ? sat_add(side_x_q, delta_x_q) : side_x_q;
	assign nx_side_y = adv_x ? side_y_q : sat_add(side_y_q, delta_y_q);
	assign nx_cell_x = adv_x ? step_cell(cur_cell_x_q, step_neg_x_q) : cur_cell_x_q;
	assign nx_cell_y = adv_x ? cur_cell_y_q : step_cell(cur_cell_y_q, step_neg_y_q);

	grdda_recip u_recip (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire && (op_t'(op) == OP_START)) state_d = ST_MUL_X;
			end
			ST_MUL_X:    state_d = ST_MUL_Y;
			ST_MUL_Y:    state_d = ST_RAY_Y;
			ST_RAY_Y:    state_d = ST_DIV_X;
			ST_DIV_X: begin
				if (div_done) state_d = ST_DIV_Y;
			end
			ST_DIV_Y: begin
				if (div_done) state_d = ST_SIDE_X;
			end
			ST_SIDE_X:   state_d = ST_SIDE_Y;
			ST_SIDE_Y:   state_d = ST_SIDE_FIN;
			ST_SIDE_FIN: state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default:     state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready    = 1'b0;
		fin_load    = 1'b0;
		div_start   = 1'b0;
		div_divisor = ray_x_mag;
		mul_a       = '0;
		mul_b       = '0;
		fin_dir     = view_dir_y_q;
		fin_neg     = offs_neg_q ^ plane_y_q[DIR_W-1];
		case (state_q)
			ST_IDLE: begin
				in_ready = out_free;
			end
			ST_MUL_X: begin
				mul_a = MUL_A_W'(plane_x_mag);
				mul_b = SPAN_W'(offs_mag_q);
			end
			ST_MUL_Y: begin
				mul_a   = MUL_A_W'(plane_y_mag);
				mul_b   = SPAN_W'(offs_mag_q);
				fin_dir = view_dir_x_q;
				fin_neg = offs_neg_q ^ plane_x_q[DIR_W-1];
			end
			ST_RAY_Y: begin
				div_start = 1'b1;
			end
			ST_DIV_X: begin
				div_start   = div_done;
				div_divisor = ray_y_mag;
			end
			ST_SIDE_X: begin
				mul_a = delta_x_q;
				mul_b = span_x;
			end
			ST_SIDE_Y: begin
				mul_a = delta_y_q;
				mul_b = span_y;
			end
			ST_DONE: begin
				fin_load = out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q      <= '0;
			pos_y_q      <= '0;
			view_dir_x_q <= VIEW_DIR_X_RESET;
			view_dir_y_q <= '0;
			plane_x_q    <= '0;
			plane_y_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_POS_X:      pos_x_q      <= cfg_data;
				REG_POS_Y:      pos_y_q      <= cfg_data;
				REG_VIEW_DIR_X: view_dir_x_q <= cfg_data[DIR_W-1:0];
				REG_VIEW_DIR_Y: view_dir_y_q <= cfg_data[DIR_W-1:0];
				REG_PLANE_X:    plane_x_q    <= cfg_data[DIR_W-1:0];
				REG_PLANE_Y:    plane_y_q    <= cfg_data[DIR_W-1:0];
				default:        ;
			endcase
		end
	end

	// traversal state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			ray_x_q      <= '0;
			ray_y_q      <= '0;
			delta_x_q    <= DIST_MAX;
			delta_y_q    <= DIST_MAX;
			side_x_q     <= '0;
			side_y_q     <= '0;
			cur_cell_x_q <= '0;
			cur_cell_y_q <= '0;
			step_neg_x_q <= 1'b0;
			step_neg_y_q <= 1'b0;
			last_side_q  <= 1'b0;
			offs_neg_q   <= 1'b0;
			offs_mag_q   <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (adv_fire) begin
						side_x_q     <= nx_side_x;
						side_y_q     <= nx_side_y;
						cur_cell_x_q <= nx_cell_x;
						cur_cell_y_q <= nx_cell_y;
						last_side_q  <= !adv_x;
					end else if (in_fire) begin
						offs_neg_q   <= offs_s[OFFS_W-1];
						offs_mag_q   <= offs_abs[OFFS_MAG_W-1:0];
						cur_cell_x_q <= CELL_W'(pos_x_q[POS_W-1:FRAC_W]);
						cur_cell_y_q <= CELL_W'(pos_y_q[POS_W-1:FRAC_W]);
						last_side_q  <= 1'b0;
					end
				end
				ST_MUL_Y: begin
					ray_x_q      <= ray_sat;
					step_neg_x_q <= ray_sat[DIR_W-1];
				end
				ST_RAY_Y: begin
					ray_y_q      <= ray_sat;
					step_neg_y_q <= ray_sat[DIR_W-1];
				end
				ST_DIV_X: begin
					if (div_done) delta_x_q <= div_quot;
				end
				ST_DIV_Y: begin
					if (div_done) delta_y_q <= div_quot;
				end
				ST_SIDE_Y: begin
					side_x_q <= side_sat;
				end
				ST_SIDE_FIN: begin
					side_y_q <= side_sat;
				end
				default: ;
			endcase
		end
	end

	// product register of the shared multiplier
	always_ff @(posedge clk) begin
		case (state_q)
			ST_MUL_X, ST_MUL_Y, ST_SIDE_X, ST_SIDE_Y: prod_q <= mul_p;
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_fire || fin_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_fire) begin
			cell_x_q    <= nx_cell_x;
			cell_y_q    <= nx_cell_y;
			hit_side_q  <= !adv_x;
			dist_x_q    <= nx_side_x;
			dist_y_q    <= nx_side_y;
			ray_x_out_q <= ray_x_q;
			ray_y_out_q <= ray_y_q;
		end else if (fin_load) begin
			cell_x_q    <= cur_cell_x_q;
			cell_y_q    <= cur_cell_y_q;
			hit_side_q  <= last_side_q;
			dist_x_q    <= side_x_q;
			dist_y_q    <= side_y_q;
			ray_x_out_q <= ray_x_q;
			ray_y_out_q <= ray_y_q;
		end
	end

	assign out_valid = out_valid_q;
	assign cell_x    = cell_x_q;
	assign cell_y    = cell_y_q;
	assign hit_side  = hit_side_q;
	assign dist_x    = dist_x_q;
	assign dist_y    = dist_y_q;
	assign ray_x     = ray_x_out_q;
	assign ray_y     = ray_y_out_q;

endmodule

// File: tb/grid_ray_dda_traversal_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_ray_dda_traversal_test: self-checking bench for the DDA ray traversal
// Queues start and advance commands under a series of camera settings, drives
// them with random gaps, and checks every report against an in-bench model of
// the ray setup and cell stepping.
// ----------------------------------------------------------------------------
module grid_ray_dda_traversal_test;
	import grdda_pkg::*;

	localparam int CYCLE_LIMIT  = 600000;
	localparam int NUM_SETTINGS = 12;
	localparam int RUN_BUDGET   = 40;

	typedef struct packed {
		op_t              op;
		logic [COL_W-1:0] column;
	} ray_cmd_t;

	typedef struct packed {
		logic signed [CELL_W-1:0] cell_x;
		logic signed [CELL_W-1:0] cell_y;
		logic                     hit_side;
		logic [DIST_W-1:0]        dist_x;
		logic [DIST_W-1:0]        dist_y;
		logic signed [DIR_W-1:0]  ray_x;
		logic signed [DIR_W-1:0]  ray_y;
	} cell_report_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]     cfg_index = REG_POS_X;
	logic [POS_W-1:0]         cfg_data = '0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic                     op = OP_START;
	logic [COL_W-1:0]         column = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic signed [CELL_W-1:0] cell_x;
	logic signed [CELL_W-1:0] cell_y;
	logic                     hit_side;
	logic [DIST_W-1:0]        dist_x;
	logic [DIST_W-1:0]        dist_y;
	logic signed [DIR_W-1:0]  ray_x;
	logic signed [DIR_W-1:0]  ray_y;

	// camera registers as the block should hold them
	logic [POS_W-1:0]        cam_pos_x = '0;
	logic [POS_W-1:0]        cam_pos_y = '0;
	logic signed [DIR_W-1:0] cam_dir_x = VIEW_DIR_X_RESET;
	logic signed [DIR_W-1:0] cam_dir_y = '0;
	logic signed [DIR_W-1:0] cam_plane_x = '0;
	logic signed [DIR_W-1:0] cam_plane_y = '0;

	// traversal state
	logic signed [DIR_W-1:0]  tr_ray_x = '0;
	logic signed [DIR_W-1:0]  tr_ray_y = '0;
	logic [DIST_W-1:0]        tr_delta_x = DIST_MAX;
	logic [DIST_W-1:0]        tr_delta_y = DIST_MAX;
	logic [DIST_W-1:0]        tr_side_x = '0;
	logic [DIST_W-1:0]        tr_side_y = '0;
	logic signed [CELL_W-1:0] tr_cell_x = '0;
	logic signed [CELL_W-1:0] tr_cell_y = '0;
	logic                     tr_neg_x = 1'b0;
	logic                     tr_neg_y = 1'b0;
	logic                     tr_side = 1'b0;

	ray_cmd_t     ray_cmds[$];
	cell_report_t pending_reports[$];

	int          items_queued = 0;
	int          results_seen = 0;
	int          mismatch_count = 0;
	int          send_idle_pct = 34;
	int          recv_idle_pct = 66;
	int unsigned cycle_count = 0;

	grid_ray_dda_traversal i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.column    (column),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cell_x    (cell_x),
		.cell_y    (cell_y),
		.hit_side  (hit_side),
		.dist_x    (dist_x),
		.dist_y    (dist_y),
		.ray_x     (ray_x),
		.ray_y     (ray_y)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// dir + plane * (2*col - W) / W, truncated toward zero, then clamped
	function automatic logic signed [DIR_W-1:0] ray_component(
		input logic signed [DIR_W-1:0] base,
		input logic signed [DIR_W-1:0] pl,
		input logic [COL_W-1:0]        col
	);
		longint offs;
		longint sum;
		offs = 2 * longint'(col) - SCREEN_COLUMNS;
		sum = longint'(base) + (longint'(pl) * offs) / SCREEN_COLUMNS;
		if (sum > longint'(RAY_MAX))
			sum = longint'(RAY_MAX);
		if (sum < longint'(RAY_MIN))
			sum = longint'(RAY_MIN);
		return DIR_W'(sum);
	endfunction

	function automatic logic [DIST_W-1:0] ray_delta(input logic signed [DIR_W-1:0] r);
		longint mag;
		if (r == 0)
			return DIST_MAX;
		mag = (r < 0) ? -longint'(r) : longint'(r);
		return DIST_W'(longint'(RECIP_NUM) / mag);
	endfunction

	function automatic logic [DIST_W-1:0] first_boundary(
		input logic [POS_W-1:0]  pos,
		input logic              neg,
		input logic [DIST_W-1:0] delta
	);
		logic [63:0] span;
		logic [63:0] prod;
		span = neg ? 64'(pos[FRAC_W-1:0]) : 64'h1_0000 - 64'(pos[FRAC_W-1:0]);
		prod = (span * 64'(delta)) >> FRAC_W;
		return (prod > 64'(DIST_MAX)) ? DIST_MAX : prod[DIST_W-1:0];
	endfunction

	function automatic logic [DIST_W-1:0] dist_add(
		input logic [DIST_W-1:0] a,
		input logic [DIST_W-1:0] b
	);
		logic [DIST_W:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];
	endfunction

	function automatic logic signed [CELL_W-1:0] cell_step(
		input logic signed [CELL_W-1:0] c,
		input logic                     neg
	);
		if (neg)
			return (c > CELL_MIN) ? c - CELL_W'(1) : c;
		return (c < CELL_MAX) ? c + CELL_W'(1) : c;
	endfunction

	function automatic cell_report_t traverse_step(input ray_cmd_t cmd);
		if (cmd.op == OP_START) begin
			tr_ray_x = ray_component(cam_dir_x, cam_plane_x, cmd.column);
			tr_ray_y = ray_component(cam_dir_y, cam_plane_y, cmd.column);
			tr_cell_x = CELL_W'(cam_pos_x[POS_W-1:FRAC_W]);
			tr_cell_y = CELL_W'(cam_pos_y[POS_W-1:FRAC_W]);
			tr_delta_x = ray_delta(tr_ray_x);
			tr_delta_y = ray_delta(tr_ray_y);
			tr_neg_x = tr_ray_x < 0;
			tr_neg_y = tr_ray_y < 0;
			tr_side_x = first_boundary(cam_pos_x, tr_neg_x, tr_delta_x);
			tr_side_y = first_boundary(cam_pos_y, tr_neg_y, tr_delta_y);
			tr_side = 1'b0;
		end else if (tr_side_x < tr_side_y) begin
			tr_side_x = dist_add(tr_side_x, tr_delta_x);
			tr_cell_x = cell_step(tr_cell_x, tr_neg_x);
			tr_side = 1'b0;
		end else begin
			// ties go to y
			tr_side_y = dist_add(tr_side_y, tr_delta_y);
			tr_cell_y = cell_step(tr_cell_y, tr_neg_y);
			tr_side = 1'b1;
		end
		return cell_report_t'{tr_cell_x, tr_cell_y, tr_side, tr_side_x, tr_side_y,
			tr_ray_x, tr_ray_y};
	endfunction

	task automatic flag_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%s", msg);
	endtask

	// driver: predict on each transfer, then present the next queued command
	always @(posedge clk) begin : drive_cmds
		ray_cmd_t next_cmd;
		if (arst_n) begin
			if (in_valid && in_ready)
				pending_reports.push_back(traverse_step(ray_cmd_t'{op_t'(op), column}));
			if (!in_valid || in_ready) begin
				if (ray_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_cmd = ray_cmds.pop_front();
					in_valid <= 1'b1;
					op <= next_cmd.op;
					column <= next_cmd.column;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: compare each transferred report with the oldest prediction
	always @(posedge clk) begin : check_reports
		cell_report_t got;
		cell_report_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				results_seen++;
				got = cell_report_t'{cell_x, cell_y, hit_side, dist_x, dist_y, ray_x, ray_y};
				if (pending_reports.size() == 0) begin
					flag_mismatch($sformatf("report %0d arrived with nothing pending",
						results_seen));
				end else begin
					want = pending_reports.pop_front();
					if (got.cell_x !== want.cell_x || got.cell_y !== want.cell_y ||
						got.hit_side !== want.hit_side || got.dist_x !== want.dist_x ||
						got.dist_y !== want.dist_y || got.ray_x !== want.ray_x ||
						got.ray_y !== want.ray_y)
						flag_mismatch($sformatf({"report %0d: expected cell %0d,%0d side %0b",
							" dist %h,%h ray %0d,%0d; got cell %0d,%0d side %0b",
							" dist %h,%h ray %0d,%0d"}, results_seen,
							want.cell_x, want.cell_y, want.hit_side, want.dist_x,
							want.dist_y, want.ray_x, want.ray_y, got.cell_x, got.cell_y,
							got.hit_side, got.dist_x, got.dist_y, got.ray_x, got.ray_y));
				end
			end
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic queue_cmd(input op_t o, input logic [COL_W-1:0] c);
		ray_cmds.push_back(ray_cmd_t'{o, c});
		items_queued++;
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (results_seen != items_queued);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [POS_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			REG_POS_X:      cam_pos_x = value;
			REG_POS_Y:      cam_pos_y = value;
			REG_VIEW_DIR_X: cam_dir_x = value[DIR_W-1:0];
			REG_VIEW_DIR_Y: cam_dir_y = value[DIR_W-1:0];
			REG_PLANE_X:    cam_plane_x = value[DIR_W-1:0];
			REG_PLANE_Y:    cam_plane_y = value[DIR_W-1:0];
			default: ;
		endcase
	endtask

	// direction registers get junk above bit 15, which must be ignored
	task automatic load_camera(
		input logic [POS_W-1:0] px,
		input logic [POS_W-1:0] py,
		input logic [DIR_W-1:0] dx,
		input logic [DIR_W-1:0] dy,
		input logic [DIR_W-1:0] plx,
		input logic [DIR_W-1:0] ply
	);
		logic [POS_W-1:0] junk;
		junk = POS_W'($urandom);
		write_reg(REG_POS_X, px);
		write_reg(REG_POS_Y, py);
		write_reg(REG_VIEW_DIR_X, {junk[POS_W-1:DIR_W], dx});
		junk = POS_W'($urandom);
		write_reg(REG_VIEW_DIR_Y, {junk[POS_W-1:DIR_W], dy});
		junk = POS_W'($urandom);
		write_reg(REG_PLANE_X, {junk[POS_W-1:DIR_W], plx});
		junk = POS_W'($urandom);
		write_reg(REG_PLANE_Y, {junk[POS_W-1:DIR_W], ply});
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [DIR_W-1:0] pick_dir();
		logic [DIR_W-1:0] d;
		case ($urandom_range(3))
			0: d = DIR_W'($urandom_range(8)) - DIR_W'(4);
			1: begin
				case ($urandom_range(4))
					0: d = RAY_MIN;
					1: d = RAY_MAX;
					2: d = '0;
					3: d = 16'h4000;
					default: d = 16'hC000;
				endcase
			end
			default: d = DIR_W'($urandom);
		endcase
		return d;
	endfunction

	// start a ray and walk it some cells; a few stray commands mixed in
	task automatic queue_rays(input int budget, input bit long_runs);
		int n;
		int steps;
		logic [COL_W-1:0] col;
		n = 0;
		while (n < budget) begin
			if ($urandom_range(9) == 0) begin
				queue_cmd(op_t'($urandom_range(1)), COL_W'($urandom));
				n++;
			end else begin
				case ($urandom_range(7))
					0: col = '0;
					1: col = '1;
					2: col = COL_W'(SCREEN_COLUMNS / 2);
					default: col = COL_W'($urandom);
				endcase
				queue_cmd(OP_START, col);
				if (long_runs && $urandom_range(3) == 0)
					steps = $urandom_range(320, 150);
				else
					steps = $urandom_range(12);
				repeat (steps) queue_cmd(OP_ADVANCE, COL_W'($urandom));
				n += steps + 1;
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset camera: advancing before any start walks the reset state
		queue_cmd(OP_ADVANCE, '0);
		queue_cmd(OP_ADVANCE, '1);
		queue_cmd(OP_ADVANCE, 10'h155);
		queue_cmd(OP_START, '0);
		queue_cmd(OP_START, '1);
		queue_cmd(OP_START, COL_W'(SCREEN_COLUMNS / 2));
		queue_cmd(OP_ADVANCE, 10'h2AA);
		queue_cmd(OP_ADVANCE, '0);
		wait_drained();

		// extreme camera: rays saturate toward the last column and are zero at column 0
		load_camera(22'h3FFFFF, 22'h000000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
		queue_cmd(OP_START, '0);
		queue_cmd(OP_START, '1);
		queue_cmd(OP_START, 10'd1);
		queue_cmd(OP_START, 10'd511);
		repeat (4) queue_cmd(OP_ADVANCE, COL_W'($urandom));
		wait_drained();
		load_camera(22'h000000, 22'h3FFFFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
		queue_cmd(OP_START, '0);
		queue_cmd(OP_START, '1);
		queue_cmd(OP_ADVANCE, '1);
		queue_cmd(OP_ADVANCE, '0);
		wait_drained();

		for (int s = 0; s < NUM_SETTINGS; s++) begin
			case (s)
				// long diagonal walk: x runs into +127, y into -128
				0: load_camera(22'h3F8000, 22'h008000, 16'h4000, 16'hC000, '0, '0);
				// both steps negative from the origin
				4: load_camera(22'h000000, 22'h000000, 16'hC000, 16'hE000, '0, '0);
				// tiny ray: distances hit the ceiling within a few steps
				8: load_camera(22'h2A5555, 22'h15AAAA, 16'h0001, 16'hFFFE, '0, '0);
				default: load_camera(POS_W'($urandom), POS_W'($urandom), pick_dir(),
					pick_dir(), pick_dir(), pick_dir());
			endcase
			if (s < 4) begin
				send_idle_pct = 34;
				recv_idle_pct = 66;
			end else if (s < 8) begin
				send_idle_pct = 66;
				recv_idle_pct = 34;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			queue_rays(RUN_BUDGET, (s % 4) == 0);
			wait_drained();
		end

		repeat (50) @(posedge clk);
		if (pending_reports.size() != 0)
			mismatch_count++;
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// File: filelist.f
hdl/grdda_pkg.sv
hdl/grdda_recip.sv
hdl/grid_ray_dda_traversal.sv
tb/grid_ray_dda_traversal_test.sv
